### src/assert_macros.svh
// Assertion macros used by the allocator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bca_pkg.sv
// Shared constants, codes and controller/datapath interface types
`default_nettype none

package bca_pkg;

	localparam int DEF_MAX_CHUNKS  = 256;
	localparam int DEF_ALIGN       = 8;

	localparam int OFF_W           = 20;
	localparam int CB_W            = 13;
	localparam int CHUNKS_W        = 9;
	localparam int CFG_W           = 13;
	localparam int CFG_IDX_W       = 1;
	localparam int SIZE_W          = 14;
	localparam int ST_W            = 2;
	localparam int DCNT_W          = $clog2(OFF_W + 1);

	localparam int CHUNK_BYTES_RST = 64;
	localparam int CHUNKS_RST      = 256;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS      = 1'b1;

	localparam logic [ST_W-1:0] ST_ALLOC = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_FREED = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic            clr_wr;
		logic            row_clr;
		logic            row_inc;
		logic            mem_rd;
		logic            rd_quot;
		logic            alloc_wr;
		logic            free_wr;
		logic            div_start;
		logic            size_quot;
		logic            size_load;
		logic            prod_load;
		logic            load_out;
		logic [ST_W-1:0] st;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic found;
		logic last_row;
		logic clr_last;
		logic out_range;
		logic out_free;
		logic size_pend;
	} sts_t;

endpackage

`default_nettype wire

### src/bitmap_chunk_allocator.sv
// Top level of the bitmap first-fit chunk allocator
// One item at a time. After reset the occupancy memory is swept clear, one row
// of up to 32 chunks per cycle, every row of the memory; in_stall stays high
// meanwhile. An allocate reads the bitmap from row 0, each row read and then
// checked in turn; a full pool is reported when the last row holding chunks
// has no free bit, and a granted offset only after the offset multiply.
// A free divides the offset by the aligned chunk size in a one-bit-per-cycle
// divider; an index that is out of range is reported without a bitmap write.
// The next item can be taken once the finished word is loaded into the output
// register. A write of chunk_bytes recomputes the aligned size with a reciprocal
// multiply, holding in_stall high and cfg_ready low until the new size is loaded.
// A finished word sits in the output register while the next item is taken.
`default_nettype none

module bitmap_chunk_allocator #(
	parameter int MAX_CHUNKS = bca_pkg::DEF_MAX_CHUNKS,
	parameter int ALIGN      = bca_pkg::DEF_ALIGN
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              op,
	input  wire  [bca_pkg::OFF_W-1:0]        release_offset,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [bca_pkg::OFF_W-1:0]        granted_offset,
	output logic [bca_pkg::ST_W-1:0]         status,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bca_pkg::CFG_W-1:0]        cfg_data
);
	import bca_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign cfg_we = cfg_valid && cfg_ready;

	bca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bca_dpath #(
		.MAX_CHUNKS (MAX_CHUNKS),
		.ALIGN      (ALIGN)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.release_offset (release_offset),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.granted_offset (granted_offset),
		.status         (status)
	);

endmodule

`default_nettype wire

### src/bca_ctrl.sv
// Sequencer for reset sweep, size update, allocate scan and free
`default_nettype none

module bca_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  wire             op,
	output logic            in_stall,
	output logic            cfg_ready,
	input  bca_pkg::sts_t   sts,
	output bca_pkg::cmd_t   cmd
);
	import bca_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SIZE,
		S_AREAD,
		S_ACHECK,
		S_AMUL,
		S_FDIV,
		S_FWRITE
	} state_t;

	state_t          state_q, state_d;
	logic            done_q, done_d;
	logic [ST_W-1:0] st_q, st_d;
	logic            accept;

	assign in_stall  = !(state_q == S_IDLE && !done_q && !sts.size_pend);
	assign cfg_ready = state_q != S_SIZE && !sts.size_pend;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.st  = st_q;
		if (done_q) begin
			if (sts.out_free) begin
				cmd.load_out = 1'b1;
				done_d       = 1'b0;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cmd.clr_wr  = 1'b1;
					cmd.row_inc = 1'b1;
					if (sts.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					if (sts.size_pend) begin
						cmd.size_quot = 1'b1;
						state_d       = S_SIZE;
					end else if (accept) begin
						if (op == OP_ALLOC) begin
							cmd.row_clr = 1'b1;
							state_d     = S_AREAD;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_FDIV;
						end
					end
				end
				S_SIZE: begin
					cmd.size_load = 1'b1;
					state_d       = S_IDLE;
				end
				S_AREAD: begin
					cmd.mem_rd = 1'b1;
					state_d    = S_ACHECK;
				end
				S_ACHECK: begin
					if (sts.found) begin
						cmd.alloc_wr = 1'b1;
						state_d      = S_AMUL;
					end else if (sts.last_row) begin
						st_d    = ST_FULL;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.row_inc = 1'b1;
						state_d     = S_AREAD;
					end
				end
				S_AMUL: begin
					cmd.prod_load = 1'b1;
					st_d          = ST_ALLOC;
					done_d        = 1'b1;
					state_d       = S_IDLE;
				end
				S_FDIV: begin
					if (sts.div_done) begin
						if (sts.out_range) begin
							st_d    = ST_RANGE;
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.mem_rd  = 1'b1;
							cmd.rd_quot = 1'b1;
							state_d     = S_FWRITE;
						end
					end
				end
				S_FWRITE: begin
					cmd.free_wr = 1'b1;
					st_d        = ST_FREED;
					done_d      = 1'b1;
					state_d     = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
			st_q    <= ST_ALLOC;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			st_q    <= st_d;
		end
	end

endmodule

`default_nettype wire

### src/bca_dpath.sv
// Occupancy memory, config registers, offset divider, offset multiplier, output register
`default_nettype none

module bca_dpath #(
	parameter int MAX_CHUNKS = bca_pkg::DEF_MAX_CHUNKS,
	parameter int ALIGN      = bca_pkg::DEF_ALIGN
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  bca_pkg::cmd_t                    cmd,
	output bca_pkg::sts_t                    sts,
	input  wire                              cfg_we,
	input  wire  [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bca_pkg::CFG_W-1:0]        cfg_data,
	input  wire  [bca_pkg::OFF_W-1:0]        release_offset,
	input  wire                              out_stall,
	output logic                             out_valid,
	output logic [bca_pkg::OFF_W-1:0]        granted_offset,
	output logic [bca_pkg::ST_W-1:0]         status
);
	import bca_pkg::*;

	localparam int IDX_W    = $clog2(MAX_CHUNKS);
	localparam int ROW_BITS = (IDX_W > 5) ? 5 : IDX_W - 1;
	localparam int ROW_W    = 2 ** ROW_BITS;
	localparam int ROW_AW   = IDX_W - ROW_BITS;
	localparam int ROWS     = 2 ** ROW_AW;
	localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);
	localparam int CMP_W    = IDX_W + 1;
	localparam int SIZE_RST = ((CHUNK_BYTES_RST + ALIGN - 1) / ALIGN) * ALIGN;
	localparam int RCP_SH   = SIZE_W + $clog2(ALIGN);
	localparam int RCP_W    = RCP_SH + 1;
	localparam int RP_W     = SIZE_W + RCP_W;
	localparam int RCP      = (2 ** RCP_SH) / ALIGN + 1;

	logic [ROW_W-1:0]        occ_mem [ROWS];
	logic [ROW_W-1:0]        rd_q;
	logic [ROW_AW-1:0]       row_q;
	logic [ROW_AW-1:0]       rd_addr, wr_addr, qrow;
	logic [ROW_BITS-1:0]     qbit, fbit;
	logic [ROW_W-1:0]        avail;
	logic [IDX_W-1:0]        base;

	logic [CB_W-1:0]         chunk_bytes_q;
	logic [CHUNKS_W-1:0]     chunks_q;
	logic                    size_pend_q;
	logic [SIZE_W-1:0]       size_q;
	logic [CNT_W-1:0]        count;

	logic [OFF_W-1:0]        dvd_q;
	logic [SIZE_W-1:0]       dsr_q, rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [SIZE_W:0]         trial;
	logic                    ge;
	logic [SIZE_W-1:0]       req, size_dvd;
	logic [RP_W-1:0]         rcp_prod;
	logic [SIZE_W-1:0]       quo_q;

	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W+SIZE_W-1:0] prod_q;

	logic                    out_valid_q;
	logic [OFF_W-1:0]        granted_q;
	logic [ST_W-1:0]         status_q;
	logic                    out_free;

	always_comb begin
		if (32'(chunks_q) > 32'(MAX_CHUNKS)) count = CNT_W'(MAX_CHUNKS);
		else count = CNT_W'(chunks_q);
	end

	assign qrow    = dvd_q[IDX_W-1:ROW_BITS];
	assign qbit    = dvd_q[ROW_BITS-1:0];
	assign rd_addr = cmd.rd_quot ? qrow : row_q;
	assign wr_addr = cmd.free_wr ? qrow : row_q;
	assign base    = {row_q, ROW_BITS'(0)};

	always_comb begin
		fbit = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			avail[b] = !rd_q[b] && ((CMP_W'(base) + CMP_W'(b)) < CMP_W'(count));
			if (avail[b]) fbit = ROW_BITS'(b);
		end
	end

	assign req      = (chunk_bytes_q == '0) ? SIZE_W'(1) : SIZE_W'(chunk_bytes_q);
	assign size_dvd = req + SIZE_W'(ALIGN - 1);
	assign rcp_prod = RP_W'(size_dvd) * RP_W'(RCP);
	assign trial    = {rem_q, dvd_q[OFF_W-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts           = '0;
		sts.div_done  = dcnt_q == '0;
		sts.found     = |avail;
		sts.last_row  = (CMP_W'(base) + CMP_W'(ROW_W)) >= CMP_W'(count);
		sts.clr_last  = &row_q;
		sts.out_range = dvd_q >= OFF_W'(count);
		sts.out_free  = out_free;
		sts.size_pend = size_pend_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) rd_q <= occ_mem[rd_addr];
		if (cmd.clr_wr) occ_mem[wr_addr] <= '0;
		else if (cmd.alloc_wr) occ_mem[wr_addr] <= rd_q | (ROW_W'(1) << fbit);
		else if (cmd.free_wr) occ_mem[wr_addr] <= rd_q & ~(ROW_W'(1) << qbit);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= release_offset;
			dsr_q <= size_q;
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			rem_q <= ge ? SIZE_W'(trial - {1'b0, dsr_q}) : SIZE_W'(trial);
			dvd_q <= {dvd_q[OFF_W-2:0], ge};
		end
		if (cmd.size_quot) quo_q <= rcp_prod[RCP_SH +: SIZE_W];
		if (cmd.alloc_wr) idx_q <= {row_q, fbit};
		if (cmd.prod_load) prod_q <= idx_q * size_q;
		if (cmd.load_out) begin
			granted_q <= (cmd.st == ST_ALLOC) ? OFF_W'(prod_q) : '0;
			status_q  <= cmd.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q         <= '0;
			dcnt_q        <= '0;
			chunk_bytes_q <= CB_W'(CHUNK_BYTES_RST);
			chunks_q      <= CHUNKS_W'(CHUNKS_RST);
			size_pend_q   <= 1'b0;
			size_q        <= SIZE_W'(SIZE_RST);
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.row_clr) row_q <= '0;
			else if (cmd.row_inc) row_q <= row_q + 1'b1;
			if (cmd.div_start) dcnt_q <= DCNT_W'(OFF_W);
			else if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.size_load) begin
				size_q      <= SIZE_W'(quo_q * ALIGN);
				size_pend_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CHUNK_BYTES: begin
						chunk_bytes_q <= cfg_data;
						size_pend_q   <= 1'b1;
					end
					CFG_CHUNKS: chunks_q <= cfg_data[CHUNKS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign granted_offset = granted_q;
	assign status         = status_q;

endmodule

`default_nettype wire

### src/bca_checker.sv
// Port-level checks for the allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bca_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire [bca_pkg::OFF_W-1:0]      granted_offset,
	input wire [bca_pkg::ST_W-1:0]       status,
	input wire                           cfg_valid,
	input wire                           cfg_ready,
	input wire [bca_pkg::CFG_IDX_W-1:0]  cfg_index
);
	import bca_pkg::*;

	`AST_SAME(a_zero_offset, clk, arst_n, out_valid && status != ST_ALLOC, granted_offset == '0, "nonzero offset on a non-allocate word")
	`AST_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while an item is in progress")
	`AST_NEXT(a_size_update, clk, arst_n, cfg_valid && cfg_ready && cfg_index == CFG_CHUNK_BYTES, in_stall, "input open during chunk size update")
	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(granted_offset) && $stable(status), "stalled output word changed")

endmodule

bind bitmap_chunk_allocator bca_checker u_bca_checker (.*);

`default_nettype wire
